// ----- sv/pmhf_pkg.sv -----
`timescale 1ns / 1ps

package pmhf_pkg;

    localparam int GAIN_BITS     = 16;
    localparam int HOLD_BITS     = 20;
    localparam int CFG_DATA_BITS = 20;
    localparam int CFG_ADDR_BITS = 1;

    localparam logic [GAIN_BITS-1:0] FALL_GAIN_RESET    = 16'd64736;
    localparam logic [HOLD_BITS-1:0] HOLD_SAMPLES_RESET = 20'd72000;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_FALL_GAIN    = 1'b0,
        REG_HOLD_SAMPLES = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic valid;
        logic stall;
    } flow_t;

endpackage

// ----- sv/peak_meter_hold_fallback.sv -----
`timescale 1ns / 1ps

// Peak meter with hold and falloff. Takes one sample request per clock while
// in_stall is low and returns exactly one registered result per sample. The
// period maximum, max-since-read, held peak and hold counter are all updated
// for each accepted sample (magnitude compare, hold countdown and one
// SAMPLE_BITS-1 by 16 multiply for the falloff), so the sustained rate is
// one sample per clock. A two-entry output buffer lets a new sample be taken
// while a result still waits on out_stall; in_stall rises only when both
// entries are full. Reported values include the update made by that sample.
module peak_meter_hold_fallback #(
    parameter int SAMPLE_BITS       = 24,
    parameter int PERIOD_COUNT_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pmhf_pkg::CFG_ADDR_BITS-1:0]    cfg_index,
    input  logic [pmhf_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic                                  end_of_period,
    input  logic                                  read_request,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [SAMPLE_BITS-2:0]                max_since_read,
    output logic [SAMPLE_BITS-2:0]                held_peak,
    output logic                                  period_done
);

    localparam int MAG_BITS  = SAMPLE_BITS - 1;
    localparam int HOLD_BITS = pmhf_pkg::HOLD_BITS;
    localparam int GAIN_BITS = pmhf_pkg::GAIN_BITS;
    localparam int CMP_BITS  = (HOLD_BITS > PERIOD_COUNT_BITS) ? HOLD_BITS
                                                               : PERIOD_COUNT_BITS;
    localparam int PROD_BITS = MAG_BITS + GAIN_BITS;
    localparam int RES_BITS  = 2 * MAG_BITS + 1;

    logic [GAIN_BITS-1:0]         fall_gain_reg;
    logic [HOLD_BITS-1:0]         hold_samples_reg;
    logic [MAG_BITS-1:0]          period_max_reg;
    logic [MAG_BITS-1:0]          running_max_reg;
    logic [MAG_BITS-1:0]          peak_value_reg;
    logic [HOLD_BITS-1:0]         hold_left_reg;
    logic                         read_pending_reg;
    logic [PERIOD_COUNT_BITS-1:0] period_count_reg;

    logic [MAG_BITS-1:0]          period_max_next;
    logic [MAG_BITS-1:0]          running_max_next;
    logic [MAG_BITS-1:0]          peak_value_next;
    logic [HOLD_BITS-1:0]         hold_left_next;
    logic                         read_pending_next;
    logic [PERIOD_COUNT_BITS-1:0] period_count_next;

    logic                         accept;
    logic [SAMPLE_BITS-1:0]       neg_sample;
    logic [MAG_BITS-1:0]          mag;
    logic [MAG_BITS-1:0]          pmax_upd;
    logic [PERIOD_COUNT_BITS-1:0] count_upd;
    logic [CMP_BITS-1:0]          hold_ext;
    logic [CMP_BITS-1:0]          count_ext;
    logic [CMP_BITS-1:0]          hold_diff;
    logic [PROD_BITS-1:0]         fall_prod;
    logic [RES_BITS-1:0]          res_data;
    logic [RES_BITS-1:0]          out_data;
    logic                         buf_full;
    pmhf_pkg::flow_t              up_flow;
    pmhf_pkg::flow_t              dn_flow;

    assign accept   = in_valid && !in_stall;
    assign in_stall = buf_full;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fall_gain_reg    <= pmhf_pkg::FALL_GAIN_RESET;
            hold_samples_reg <= pmhf_pkg::HOLD_SAMPLES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (pmhf_pkg::cfg_index_t'(cfg_index))
                pmhf_pkg::REG_FALL_GAIN:
                    fall_gain_reg <= cfg_data[GAIN_BITS-1:0];
                pmhf_pkg::REG_HOLD_SAMPLES:
                    hold_samples_reg <= cfg_data[HOLD_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // magnitude, saturating the most negative code
    always_comb
    begin
        neg_sample = ~sample + {{(SAMPLE_BITS-1){1'b0}}, 1'b1};
        if (sample[SAMPLE_BITS-1])
        begin
            mag = neg_sample[SAMPLE_BITS-1] ? {MAG_BITS{1'b1}} : neg_sample[MAG_BITS-1:0];
        end
        else
        begin
            mag = sample[MAG_BITS-1:0];
        end
    end

    assign pmax_upd  = (mag > period_max_reg) ? mag : period_max_reg;
    assign count_upd = (&period_count_reg) ? period_count_reg
                     : period_count_reg + {{(PERIOD_COUNT_BITS-1){1'b0}}, 1'b1};
    assign hold_ext  = CMP_BITS'(hold_left_reg);
    assign count_ext = CMP_BITS'(count_upd);
    assign hold_diff = hold_ext - count_ext;
    assign fall_prod = PROD_BITS'(peak_value_reg) * PROD_BITS'(fall_gain_reg);

    always_comb
    begin
        running_max_next  = running_max_reg;
        peak_value_next   = peak_value_reg;
        hold_left_next    = hold_left_reg;
        period_max_next   = pmax_upd;
        period_count_next = count_upd;
        read_pending_next = read_pending_reg || read_request;
        if (end_of_period)
        begin
            period_max_next   = '0;
            period_count_next = '0;
            read_pending_next = read_request;
            if (read_pending_reg || (pmax_upd > running_max_reg))
            begin
                running_max_next = pmax_upd;
            end
            if (pmax_upd >= peak_value_reg)
            begin
                peak_value_next = pmax_upd;
                hold_left_next  = hold_samples_reg;
            end
            else if (hold_left_reg != '0)
            begin
                hold_left_next = (hold_ext > count_ext) ? hold_diff[HOLD_BITS-1:0] : '0;
            end
            else
            begin
                peak_value_next = fall_prod[PROD_BITS-1:GAIN_BITS];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_max_reg   <= '0;
            running_max_reg  <= '0;
            peak_value_reg   <= '0;
            hold_left_reg    <= '0;
            read_pending_reg <= 1'b0;
            period_count_reg <= '0;
        end
        else if (accept)
        begin
            period_max_reg   <= period_max_next;
            running_max_reg  <= running_max_next;
            peak_value_reg   <= peak_value_next;
            hold_left_reg    <= hold_left_next;
            read_pending_reg <= read_pending_next;
            period_count_reg <= period_count_next;
        end
    end

    assign res_data      = {running_max_next, peak_value_next, end_of_period};
    assign up_flow.valid = accept;
    assign up_flow.stall = out_stall;

    pmhf_outbuf #(
        .WIDTH (RES_BITS)
    ) u_outbuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .up      (up_flow),
        .up_data (res_data),
        .up_full (buf_full),
        .dn      (dn_flow),
        .dn_data (out_data)
    );

    assign out_valid      = dn_flow.valid;
    assign max_since_read = out_data[RES_BITS-1:MAG_BITS+1];
    assign held_peak      = out_data[MAG_BITS:1];
    assign period_done    = out_data[0];

    a_eop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_period |=> (period_count_reg == '0) && (period_max_reg == '0))
        else $error("period state not cleared at period end");

    a_read_latched: assert property (@(posedge clk) disable iff (!rst_n)
        accept && read_request |=> read_pending_reg)
        else $error("read request lost");

    a_running_floor: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_period |=> running_max_reg >= $past(pmax_upd))
        else $error("period maximum not reflected in max since read");

endmodule

// ----- sv/pmhf_outbuf.sv -----
`timescale 1ns / 1ps

module pmhf_outbuf #(
    parameter int WIDTH = 47
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pmhf_pkg::flow_t  up,
    input  logic [WIDTH-1:0] up_data,
    output logic             up_full,
    output pmhf_pkg::flow_t  dn,
    output logic [WIDTH-1:0] dn_data
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic [WIDTH-1:0] out_data_reg;
    logic [WIDTH-1:0] skid_data_reg;
    logic             out_fire;
    logic             up_fire;

    assign up_full  = skid_valid_reg;
    assign out_fire = out_valid_reg && !dn.stall;
    assign up_fire  = up.valid && !skid_valid_reg;

    assign dn.valid = out_valid_reg;
    assign dn.stall = up.stall;
    assign dn_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (up_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (up_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_data_reg <= up_data;
            end
            else
            begin
                out_data_reg <= up_data;
            end
        end
    end

    // skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int SAMPLE_BITS   = 24;
    localparam int PCOUNT_BITS   = 16;
    localparam int MAG_BITS      = SAMPLE_BITS - 1;
    localparam int GAIN_BITS     = pmhf_pkg::GAIN_BITS;
    localparam int HOLD_BITS     = pmhf_pkg::HOLD_BITS;
    localparam int CFG_DATA_BITS = pmhf_pkg::CFG_DATA_BITS;
    localparam logic [MAG_BITS-1:0] MAG_MAX = '1;

    typedef struct {
        logic [MAG_BITS-1:0] max_since_read;
        logic [MAG_BITS-1:0] held_peak;
        logic                period_done;
    } meter_reading_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    pmhf_pkg::cfg_index_t         cfg_index = pmhf_pkg::REG_FALL_GAIN;
    logic [CFG_DATA_BITS-1:0]     cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [SAMPLE_BITS-1:0] sample = '0;
    logic                         end_of_period = 1'b0;
    logic                         read_request = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [MAG_BITS-1:0]          max_since_read;
    logic [MAG_BITS-1:0]          held_peak;
    logic                         period_done;

    // meter state mirrored for prediction
    logic [GAIN_BITS-1:0]   mtr_gain = pmhf_pkg::FALL_GAIN_RESET;
    logic [HOLD_BITS-1:0]   mtr_hold_cfg = pmhf_pkg::HOLD_SAMPLES_RESET;
    logic [MAG_BITS-1:0]    mtr_period_max = '0;
    logic [MAG_BITS-1:0]    mtr_running_max = '0;
    logic [MAG_BITS-1:0]    mtr_peak = '0;
    logic [HOLD_BITS-1:0]   mtr_hold_left = '0;
    logic                   mtr_read_pending = 1'b0;
    logic [PCOUNT_BITS-1:0] mtr_count = '0;

    meter_reading_t expected_readings[$];
    int             errors = 0;
    bit             quiet = 1'b0;

    peak_meter_hold_fallback #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .PERIOD_COUNT_BITS(PCOUNT_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .end_of_period (end_of_period),
        .read_request  (read_request),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .max_since_read(max_since_read),
        .held_peak     (held_peak),
        .period_done   (period_done)
    );

    always #5 clk = ~clk;

    function automatic logic [MAG_BITS-1:0] sample_magnitude(logic signed [SAMPLE_BITS-1:0] s);
        logic [SAMPLE_BITS-1:0] neg;
        begin
            if (!s[SAMPLE_BITS-1])
                return s[MAG_BITS-1:0];
            neg = ~s + 1'b1;
            return (neg > {1'b0, MAG_MAX}) ? MAG_MAX : neg[MAG_BITS-1:0];
        end
    endfunction

    function automatic void predict_meter(logic signed [SAMPLE_BITS-1:0] s, logic eop,
                                          logic rd);
        logic [MAG_BITS-1:0]           mag;
        logic [MAG_BITS+GAIN_BITS-1:0] prod;
        meter_reading_t                r;
        begin
            mag = sample_magnitude(s);
            if (mag > mtr_period_max)
                mtr_period_max = mag;
            if (mtr_count != '1)
                mtr_count = mtr_count + 1'b1;
            if (eop)
            begin
                if (mtr_read_pending)
                begin
                    mtr_running_max  = mtr_period_max;
                    mtr_read_pending = 1'b0;
                end
                else if (mtr_period_max > mtr_running_max)
                    mtr_running_max = mtr_period_max;
                if (mtr_period_max >= mtr_peak)
                begin
                    mtr_peak      = mtr_period_max;
                    mtr_hold_left = mtr_hold_cfg;
                end
                else if (mtr_hold_left != '0)
                    mtr_hold_left = (mtr_hold_left > HOLD_BITS'(mtr_count)) ?
                                    mtr_hold_left - HOLD_BITS'(mtr_count) : '0;
                else
                begin
                    prod     = mtr_peak * mtr_gain;
                    mtr_peak = prod[MAG_BITS+GAIN_BITS-1:GAIN_BITS];
                end
                mtr_period_max = '0;
                mtr_count      = '0;
            end
            if (rd)
                mtr_read_pending = 1'b1;
            r.max_since_read = mtr_running_max;
            r.held_peak      = mtr_peak;
            r.period_done    = eop;
            expected_readings.push_back(r);
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample(bit soft_level);
        logic signed [SAMPLE_BITS-1:0] s;
        begin
            if (soft_level)
                s = SAMPLE_BITS'($signed($urandom_range(511)) - 256);
            else
                case ($urandom_range(9))
                    0: s = {1'b0, MAG_MAX};
                    1: s = {1'b1, {MAG_BITS{1'b0}}};
                    2: s = '0;
                    3: s = SAMPLE_BITS'($signed($urandom_range(511)) - 256);
                    default: s = SAMPLE_BITS'($urandom());
                endcase
            return s;
        end
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic eop,
                               input logic rd);
        begin
            while (!quiet && $urandom_range(99) < 19)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid      <= 1'b1;
            sample        <= s;
            end_of_period <= eop;
            read_request  <= rd;
            do
                @(posedge clk);
            while (in_stall);
            predict_meter(s, eop, rd);
        end
    endtask

    task automatic wait_idle();
        begin
            in_valid <= 1'b0;
            while (expected_readings.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic configure(input logic [CFG_DATA_BITS-1:0] gain_word,
                             input logic [CFG_DATA_BITS-1:0] hold_word);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= pmhf_pkg::REG_FALL_GAIN;
            cfg_data  <= gain_word;
            @(posedge clk);
            cfg_index <= pmhf_pkg::REG_HOLD_SAMPLES;
            cfg_data  <= hold_word;
            @(posedge clk);
            cfg_we <= 1'b0;
            @(posedge clk);
            mtr_gain     = gain_word[GAIN_BITS-1:0];
            mtr_hold_cfg = hold_word[HOLD_BITS-1:0];
        end
    endtask

    // reset config: extremes, saturating magnitude, reads on and off period end
    task automatic test_extremes();
        begin
            send_sample(0, 1'b1, 1'b0);
            send_sample({1'b0, MAG_MAX}, 1'b0, 1'b0);
            send_sample({1'b1, {MAG_BITS{1'b0}}}, 1'b1, 1'b0);
            send_sample(-1, 1'b1, 1'b1);
            send_sample(1, 1'b0, 1'b0);
            send_sample(0, 1'b1, 1'b0);
            send_sample(-5, 1'b0, 1'b1);
            send_sample(3, 1'b1, 1'b0);
            send_sample(100, 1'b1, 1'b0);
            wait_idle();
        end
    endtask

    // falloff at full and zero gain, equal peak reload, masked register data
    task automatic test_falloff();
        begin
            configure(20'hFFFFF, 20'h0);
            send_sample({1'b0, MAG_MAX}, 1'b1, 1'b0);
            send_sample(10, 1'b1, 1'b0);
            send_sample(-12, 1'b1, 1'b0);
            send_sample({1'b0, mtr_peak}, 1'b1, 1'b0);
            send_sample(7, 1'b1, 1'b0);
            wait_idle();
            configure(20'hF0000, 20'h0);
            send_sample(5, 1'b1, 1'b0);
            send_sample(0, 1'b1, 1'b0);
            wait_idle();
        end
    endtask

    // hold counts down by period length and saturates at zero before falling
    task automatic test_hold_countdown();
        begin
            configure(20'h08000, 20'd7);
            send_sample(50, 1'b1, 1'b0);
            repeat (3)
            begin
                send_sample(1, 1'b0, 1'b0);
                send_sample(-2, 1'b0, 1'b0);
                send_sample(3, 1'b1, 1'b0);
            end
            send_sample(4, 1'b1, 1'b0);
            wait_idle();
        end
    endtask

    // five random-period configurations; one runs with no idling on either side
    task automatic test_random_periods();
        logic [CFG_DATA_BITS-1:0] gains[5];
        logic [CFG_DATA_BITS-1:0] holds[5];
        int                       sent;
        int                       len;
        bit                       soft_level;
        begin
            gains = '{20'hFFFFF, 20'h00000, 20'h08000, 20'h0FCE0, CFG_DATA_BITS'($urandom())};
            holds = '{20'h00000, 20'hFFFFF, 20'd3, 20'd40,
                      CFG_DATA_BITS'($urandom_range(0, 64))};
            for (int p = 0; p < 5; p++)
            begin
                configure(gains[p], holds[p]);
                quiet = (p == 2);
                sent  = 0;
                while (sent < 90)
                begin
                    len        = ($urandom_range(9) == 0) ? $urandom_range(10, 30)
                                                          : $urandom_range(1, 6);
                    soft_level = ($urandom_range(9) < 4);
                    for (int k = 0; k < len; k++)
                        send_sample(random_sample(soft_level),
                                    (k == len - 1) || ($urandom_range(19) == 0),
                                    $urandom_range(99) < 15);
                    sent += len;
                end
                wait_idle();
                quiet = 1'b0;
            end
        end
    endtask

    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(99) < 19);

    always @(posedge clk)
    begin
        meter_reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("unexpected result: max_since_read %0d held_peak %0d period_done %0d",
                       max_since_read, held_peak, period_done);
                errors++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (max_since_read !== want.max_since_read)
                begin
                    $error("max_since_read: expected %0d, actual %0d",
                           want.max_since_read, max_since_read);
                    errors++;
                end
                if (held_peak !== want.held_peak)
                begin
                    $error("held_peak: expected %0d, actual %0d", want.held_peak, held_peak);
                    errors++;
                end
                if (period_done !== want.period_done)
                begin
                    $error("period_done: expected %0d, actual %0d",
                           want.period_done, period_done);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_falloff();
        test_hold_countdown();
        test_random_periods();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- peak_meter_hold_fallback.f -----
sv/pmhf_pkg.sv
sv/pmhf_outbuf.sv
sv/peak_meter_hold_fallback.sv
tb/sv/tb.sv
